FILE: sv/tlvd_pkg.sv
// Shared types and constants for the type-length-value deframer.
`default_nettype none
package tlvd_pkg;

    localparam int RESULT_FIFO_DEPTH = 4;
    localparam int RESULT_FIFO_AW    = $clog2(RESULT_FIFO_DEPTH);
    localparam int RESULT_FIFO_CW    = $clog2(RESULT_FIFO_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE_CODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_CODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_TYPE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_BAD_LENGTH  = 2'd0;
    localparam logic [1:0] ERR_SHORT_START = 2'd1;
    localparam logic [1:0] ERR_LONE_MIDDLE = 2'd2;
    localparam logic [1:0] ERR_LONE_END    = 2'd3;

    typedef struct packed {
        logic [31:0] start_code;
        logic [31:0] middle_code;
        logic [31:0] end_code;
        logic [31:0] error_type;
        logic [30:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] msg_type;
        logic        has_byte;
        logic [7:0]  data_out;
        logic        last;
        logic        from_fragments;
        logic [1:0]  error_code;
    } result_t;

    // Results pushed by the parser in one cycle, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(logic [1:0] kind, logic [31:0] msg_type,
                                            logic has_byte, logic [7:0] data_out,
                                            logic last, logic from_fragments,
                                            logic [1:0] error_code);
        result_t r;
        r.kind           = kind;
        r.msg_type       = msg_type;
        r.has_byte       = has_byte;
        r.data_out       = data_out;
        r.last           = last;
        r.from_fragments = from_fragments;
        r.error_code     = error_code;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/tlvd_parser.sv
// Header parse, payload tagging, reassembly state: one byte per cycle unless held.
`default_nettype none
module tlvd_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tlvd_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            room_for_two,
    output tlvd_pkg::push_t      push
);

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_PLAIN,
        MODE_START,
        MODE_MID,
        MODE_END
    } mode_t;

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        fire;

    logic [63:0] header_shift_reg, header_shift_next;
    logic [31:0] frame_type_reg, frame_type_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic        in_payload_reg, in_payload_next;
    logic [30:0] bytes_left_reg, bytes_left_next;
    logic        assembling_reg, assembling_next;
    logic [31:0] assembled_type_reg, assembled_type_next;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    mode_t       mode_reg, mode_next;

    tlvd_pkg::push_t push_next;

    assign fire     = byte_valid_reg && room_for_two;
    assign in_ready = !byte_valid_reg || fire;

    always_comb begin
        logic [63:0]       shifted;
        logic              len_bad;
        logic [30:0]       len;
        logic              final_byte;
        logic [1:0]        n;
        tlvd_pkg::result_t r;
        mode_t             enter_mode;
        logic              enter;

        header_shift_next   = header_shift_reg;
        frame_type_next     = frame_type_reg;
        header_count_next   = header_count_reg;
        in_payload_next     = in_payload_reg;
        bytes_left_next     = bytes_left_reg;
        assembling_next     = assembling_reg;
        assembled_type_next = assembled_type_reg;
        prefix_count_next   = prefix_count_reg;
        mode_next           = mode_reg;
        push_next           = '0;
        n                   = 2'd0;
        r                   = '0;
        enter               = 1'b0;
        enter_mode          = MODE_SKIP;

        shifted    = {header_shift_reg[55:0], byte_reg};
        len_bad    = shifted[63] || (shifted[62:31] != 32'd0) ||
                     (shifted[30:0] > cfg.max_length);
        len        = shifted[30:0];
        final_byte = (bytes_left_reg <= 31'd1);

        if (!in_payload_reg) begin
            header_shift_next = shifted;
            header_count_next = header_count_reg + 4'd1;
            if (header_count_reg == 4'd3) begin
                frame_type_next = shifted[31:0];
            end
            if (header_count_reg == 4'd11) begin
                if (len_bad) begin
                    if (assembling_reg) begin
                        r = tlvd_pkg::make_result(tlvd_pkg::KIND_DISCARD, assembled_type_reg,
                                                  1'b0, 8'd0, 1'b0, 1'b1, 2'd0);
                        push_next.first = r;
                        n = 2'd1;
                    end
                    assembling_next     = 1'b0;
                    assembled_type_next = '0;
                    prefix_count_next   = '0;
                    r = tlvd_pkg::make_result(tlvd_pkg::KIND_ERROR, cfg.error_type,
                                              1'b0, 8'd0, 1'b1, 1'b0,
                                              tlvd_pkg::ERR_BAD_LENGTH);
                    if (n == 2'd0) push_next.first = r; else push_next.second = r;
                    n = n + 2'd1;
                    // Resynchronize: the next byte starts a new header.
                    in_payload_next   = 1'b0;
                    header_count_next = '0;
                    header_shift_next = '0;
                    bytes_left_next   = '0;
                    mode_next         = MODE_SKIP;
                end else if (frame_type_reg == cfg.start_code) begin
                    if (assembling_reg) begin
                        r = tlvd_pkg::make_result(tlvd_pkg::KIND_DISCARD, assembled_type_reg,
                                                  1'b0, 8'd0, 1'b0, 1'b1, 2'd0);
                        push_next.first = r;
                        n = 2'd1;
                    end
                    assembling_next     = 1'b0;
                    assembled_type_next = '0;
                    prefix_count_next   = '0;
                    enter = 1'b1;
                    if (len < 31'd4) begin
                        r = tlvd_pkg::make_result(tlvd_pkg::KIND_ERROR, cfg.error_type,
                                                  1'b0, 8'd0, 1'b1, 1'b0,
                                                  tlvd_pkg::ERR_SHORT_START);
                        if (n == 2'd0) push_next.first = r; else push_next.second = r;
                        n = n + 2'd1;
                        enter_mode = MODE_SKIP;
                    end else begin
                        assembling_next = 1'b1;
                        enter_mode      = MODE_START;
                    end
                end else if (frame_type_reg == cfg.middle_code) begin
                    enter = 1'b1;
                    if (!assembling_reg) begin
                        push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_ERROR,
                            cfg.error_type, 1'b0, 8'd0, 1'b1, 1'b0,
                            tlvd_pkg::ERR_LONE_MIDDLE);
                        n = 2'd1;
                        enter_mode = MODE_SKIP;
                    end else begin
                        enter_mode = MODE_MID;
                    end
                end else if (frame_type_reg == cfg.end_code) begin
                    enter = 1'b1;
                    if (!assembling_reg) begin
                        push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_ERROR,
                            cfg.error_type, 1'b0, 8'd0, 1'b1, 1'b0,
                            tlvd_pkg::ERR_LONE_END);
                        n = 2'd1;
                        enter_mode = MODE_SKIP;
                    end else begin
                        if (len == 31'd0) begin
                            // An empty end fragment closes the message with no byte.
                            push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_DATA,
                                assembled_type_reg, 1'b0, 8'd0, 1'b1, 1'b1, 2'd0);
                            n = 2'd1;
                            assembling_next     = 1'b0;
                            assembled_type_next = '0;
                            prefix_count_next   = '0;
                        end
                        enter_mode = MODE_END;
                    end
                end else begin
                    enter = 1'b1;
                    if (len == 31'd0) begin
                        push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_DATA,
                            frame_type_reg, 1'b0, 8'd0, 1'b1, 1'b0, 2'd0);
                        n = 2'd1;
                    end
                    enter_mode = MODE_PLAIN;
                end

                if (enter) begin
                    header_count_next = '0;
                    header_shift_next = '0;
                    if (len == 31'd0) begin
                        in_payload_next = 1'b0;
                        bytes_left_next = '0;
                        mode_next       = MODE_SKIP;
                    end else begin
                        in_payload_next = 1'b1;
                        bytes_left_next = len;
                        mode_next       = enter_mode;
                    end
                end
            end
        end else begin
            case (mode_reg)
                MODE_PLAIN: begin
                    push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_DATA,
                        frame_type_reg, 1'b1, byte_reg, final_byte, 1'b0, 2'd0);
                    n = 2'd1;
                end
                MODE_START: begin
                    // The first four payload bytes carry the message type.
                    if (prefix_count_reg < 3'd4) begin
                        assembled_type_next = {assembled_type_reg[23:0], byte_reg};
                        prefix_count_next   = prefix_count_reg + 3'd1;
                    end else begin
                        push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_DATA,
                            assembled_type_reg, 1'b1, byte_reg, 1'b0, 1'b1, 2'd0);
                        n = 2'd1;
                    end
                end
                MODE_MID: begin
                    push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_DATA,
                        assembled_type_reg, 1'b1, byte_reg, 1'b0, 1'b1, 2'd0);
                    n = 2'd1;
                end
                MODE_END: begin
                    push_next.first = tlvd_pkg::make_result(tlvd_pkg::KIND_DATA,
                        assembled_type_reg, 1'b1, byte_reg, final_byte, 1'b1, 2'd0);
                    n = 2'd1;
                    if (final_byte) begin
                        assembling_next     = 1'b0;
                        assembled_type_next = '0;
                        prefix_count_next   = '0;
                    end
                end
                default: begin
                end
            endcase
            if (final_byte) begin
                in_payload_next   = 1'b0;
                header_count_next = '0;
                header_shift_next = '0;
                bytes_left_next   = '0;
                mode_next         = MODE_SKIP;
            end else begin
                bytes_left_next = bytes_left_reg - 31'd1;
            end
        end

        push_next.count = n;
        if (!fire) begin
            push_next.count = 2'd0;
        end
    end

    assign push = push_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg     <= 1'b0;
            header_shift_reg   <= '0;
            frame_type_reg     <= '0;
            header_count_reg   <= '0;
            in_payload_reg     <= 1'b0;
            bytes_left_reg     <= '0;
            assembling_reg     <= 1'b0;
            assembled_type_reg <= '0;
            prefix_count_reg   <= '0;
            mode_reg           <= MODE_SKIP;
        end else begin
            if (in_ready) begin
                byte_valid_reg <= in_valid;
            end
            if (fire) begin
                header_shift_reg   <= header_shift_next;
                frame_type_reg     <= frame_type_next;
                header_count_reg   <= header_count_next;
                in_payload_reg     <= in_payload_next;
                bytes_left_reg     <= bytes_left_next;
                assembling_reg     <= assembling_next;
                assembled_type_reg <= assembled_type_next;
                prefix_count_reg   <= prefix_count_next;
                mode_reg           <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tlvd_result_fifo.sv
// Small result queue that takes up to two results per cycle and delivers one.
`default_nettype none
module tlvd_result_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tlvd_pkg::push_t   push,
    output logic                   room_for_two,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tlvd_pkg::result_t      out_result
);

    tlvd_pkg::result_t mem [tlvd_pkg::RESULT_FIFO_DEPTH];

    logic [tlvd_pkg::RESULT_FIFO_AW-1:0] wr_ptr_reg;
    logic [tlvd_pkg::RESULT_FIFO_AW-1:0] rd_ptr_reg;
    logic [tlvd_pkg::RESULT_FIFO_CW-1:0] count_reg;
    logic [tlvd_pkg::RESULT_FIFO_CW-1:0] count_next;
    logic [tlvd_pkg::RESULT_FIFO_AW-1:0] wr_ptr_plus1;
    logic                                pop;

    assign out_valid    = (count_reg != '0);
    assign out_result   = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room_for_two = (count_reg <= tlvd_pkg::RESULT_FIFO_CW'(tlvd_pkg::RESULT_FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg + tlvd_pkg::RESULT_FIFO_CW'(push.count);
        if (pop) begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + tlvd_pkg::RESULT_FIFO_AW'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tlv_deframer_with_reassembly.sv
// Top level of the type-length-value deframer with fragment reassembly.
// The slave channel carries the framed byte stream, one byte per transaction:
// each frame is a 4-byte big-endian type, an 8-byte big-endian length and
// the payload. The master channel carries one result per transaction: payload
// bytes tagged with their type (cut-through), error reports and discard
// markers for abandoned reassemblies. Configuration registers are written
// through the plain write port; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// A byte accepted from the slave channel is parsed into the result queue,
// which offers its first result (input register, then the result queue).
// Throughput is one byte per cycle while the queue has room for two results;
// the header byte that closes a header may queue two results, which the
// four-entry queue absorbs; the per-byte parse is a single registered stage.
// Reset (synchronous, aresetn low) empties the queue, returns the parser to
// header search with no open reassembly and restores the register defaults.
// When the receiver stalls, results wait in the queue; once fewer than two
// entries are free the parser holds its byte and s_tready drops.
`default_nettype none
module tlv_deframer_with_reassembly (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tlvd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tlvd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [31:0] msg_type, [39:32] data_out, [41:40] error_code, [47:42] zero
    output logic [47:0]                           m_tdata,
    output logic                                  m_tlast,   // last
    // [1:0] kind, [2] has_byte, [3] from_fragments
    output logic [3:0]                            m_tuser
);

    tlvd_pkg::cfg_t    cfg_reg;
    tlvd_pkg::push_t   push;
    tlvd_pkg::result_t out_result;
    logic              room_for_two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code  <= 32'd1;
            cfg_reg.middle_code <= 32'd2;
            cfg_reg.end_code    <= 32'd3;
            cfg_reg.error_type  <= 32'd0;
            cfg_reg.max_length  <= 31'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tlvd_pkg::CFG_START_CODE:  cfg_reg.start_code  <= cfg_wr_data;
                tlvd_pkg::CFG_MIDDLE_CODE: cfg_reg.middle_code <= cfg_wr_data;
                tlvd_pkg::CFG_END_CODE:    cfg_reg.end_code    <= cfg_wr_data;
                tlvd_pkg::CFG_ERROR_TYPE:  cfg_reg.error_type  <= cfg_wr_data;
                tlvd_pkg::CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_wr_data[30:0];
                default: begin
                end
            endcase
        end
    end

    tlvd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .room_for_two (room_for_two),
        .push         (push)
    );

    tlvd_result_fifo u_result_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (out_result)
    );

    assign m_tdata = {6'd0, out_result.error_code, out_result.data_out, out_result.msg_type};
    assign m_tlast = out_result.last;
    assign m_tuser = {out_result.from_fragments, out_result.has_byte, out_result.kind};

endmodule
`default_nettype wire
